// ===== design/msl_pkg.sv =====
// Shared types, constants and helper types for the multi-servo slew limiter.
package msl_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int CHPORT_W = 3;
    localparam int ANG_W    = 8;
    localparam int ACT_W    = 4;
    localparam int STEP_W   = 8;
    localparam int PULSE_W  = 13;
    localparam int CFGIDX_W = 2;

    // Parameter defaults.
    localparam int CHANNELS_DEF      = 8;
    localparam int FRACTION_BITS_DEF = 4;

    // Register reset values.
    localparam logic [ACT_W-1:0]   ACTIVE_RST = ACT_W'(8);
    localparam logic [STEP_W-1:0]  STEP_RST   = STEP_W'(16);
    localparam logic [PULSE_W-1:0] PMIN_RST   = PULSE_W'(500);
    localparam logic [PULSE_W-1:0] PMAX_RST   = PULSE_W'(2500);
    localparam logic [ANG_W-1:0]   LIM_HI_RST = ANG_W'(180);

    // Pulse scaling: degrees times span, divided by full scale.
    localparam int FULL_SCALE_DEG = 180;
    localparam int PROD_W         = ANG_W + PULSE_W;            // deg * |span|
    localparam int DIV_SHIFT      = PROD_W;
    localparam int DIV_RECIP      = (1 << DIV_SHIFT) / FULL_SCALE_DEG;
    localparam int RECIP_W        = 14;
    localparam int QUO_W          = 14;                          // max quotient 11603
    localparam int PSUM_W         = 16;                          // signed pulse sum
    localparam int PULSE_CAP      = 8191;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_CHANGE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [CFGIDX_W-1:0] {
        REG_ACTIVE = 2'd0,
        REG_STEP   = 2'd1,
        REG_PMIN   = 2'd2,
        REG_PMAX   = 2'd3
    } t_reg;

    typedef struct packed {
        logic [ACT_W-1:0]   active;
        logic [STEP_W-1:0]  step;
        logic [PULSE_W-1:0] pmin;
        logic [PULSE_W-1:0] pmax;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // word accepted this cycle
        logic step;   // read channel, step it, write back
        logic mul;    // degrees times span
        logic div;    // reciprocal multiply
        logic fix;    // quotient correction and sign
        logic emit;   // saturate and drive the result word
        logic next;   // advance to the next channel
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_tick;  // incoming word is a tick
        logic empty;    // no active channels
        logic last;     // channel in flight is the final active one
    } t_dp_status;

endpackage

// ===== design/msl_ctrl.sv =====
// Controller state machine that sequences the per-channel tick pipeline.
module msl_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  msl_pkg::t_dp_status    i_status,
    output msl_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_STEP = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIX  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_status.is_tick && !i_status.empty) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_FIX;
            S_FIX:  n_state = S_OUT;
            S_OUT: begin
                n_state = i_status.last ? S_IDLE : S_STEP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.step = (r_state == S_STEP);
    assign o_cmd.mul  = (r_state == S_MUL);
    assign o_cmd.div  = (r_state == S_DIV);
    assign o_cmd.fix  = (r_state == S_FIX);
    assign o_cmd.emit = (r_state == S_OUT);
    assign o_cmd.next = (r_state == S_OUT) && !i_status.last;

endmodule

// ===== design/msl_datapath.sv =====
// Channel state storage, command execution and the pulse-width arithmetic.
module msl_datapath #(
    parameter int CHANNELS      = msl_pkg::CHANNELS_DEF,
    parameter int FRACTION_BITS = msl_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msl_pkg::t_cfg                       i_cfg,
    input  msl_pkg::t_dp_cmd                    i_cmd,
    output msl_pkg::t_dp_status                 o_status,
    input  logic [msl_pkg::CMD_W-1:0]           i_command,
    input  logic [msl_pkg::CHPORT_W-1:0]        i_channel,
    input  logic [msl_pkg::ANG_W-1:0]           i_angle,
    input  logic signed [msl_pkg::ANG_W-1:0]    i_bias,
    input  logic [msl_pkg::ANG_W-1:0]           i_min_angle,
    input  logic [msl_pkg::ANG_W-1:0]           i_max_angle,
    output logic                                o_valid,
    output logic [msl_pkg::CHPORT_W-1:0]        o_out_channel,
    output logic [msl_pkg::PULSE_W-1:0]         o_pulse_us,
    output logic                                o_moved,
    output logic                                o_last
);

    localparam int ANG_W   = msl_pkg::ANG_W;
    localparam int CW      = ANG_W + FRACTION_BITS;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW      = $clog2(CHANNELS + 1);
    localparam int PROD_W  = msl_pkg::PROD_W;
    localparam int QUO_W   = msl_pkg::QUO_W;
    localparam int PSUM_W  = msl_pkg::PSUM_W;
    localparam int PULSE_W = msl_pkg::PULSE_W;
    localparam int FULL_W  = PROD_W + msl_pkg::RECIP_W;
    localparam logic [CW-1:0] CUR_MAX = '1;

    // Per-channel state.
    logic [ANG_W-1:0] r_lim_lo [CHANNELS];
    logic [ANG_W-1:0] r_lim_hi [CHANNELS];
    logic [ANG_W-1:0] r_tgt    [CHANNELS];
    logic [CW-1:0]    r_cur    [CHANNELS];

    // Tick pipeline.
    logic [CH_W-1:0]         r_idx;
    logic                    r_moved;
    logic                    r_last;
    logic [CH_W-1:0]         r_ch;
    logic [ANG_W-1:0]        r_deg;
    logic                    r_neg;
    logic [PULSE_W-1:0]      r_mag;
    logic [PROD_W-1:0]       r_prod;
    logic [QUO_W-1:0]        r_quo0;
    logic signed [QUO_W:0]   r_qs;

    function automatic logic [ANG_W-1:0] clamp_lim(
        input logic signed [ANG_W+1:0] x,
        input logic [ANG_W-1:0]        lo,
        input logic [ANG_W-1:0]        hi
    );
        logic [ANG_W-1:0] res;
        if (x < $signed({2'b00, lo})) begin
            res = lo;
        end else if (x > $signed({2'b00, hi})) begin
            res = hi;
        end else begin
            res = x[ANG_W-1:0];
        end
        return res;
    endfunction

    // Effective channel count, saturated to the storage depth.
    logic [NW-1:0] live_n;
    always_comb begin
        if (32'(i_cfg.active) > CHANNELS) begin
            live_n = NW'(CHANNELS);
        end else begin
            live_n = NW'(i_cfg.active);
        end
    end

    logic            in_range;
    logic [CH_W-1:0] wr_idx;
    logic            edit;
    assign in_range = (32'(i_channel) < 32'(live_n));
    assign wr_idx   = CH_W'(i_channel);
    assign edit     = i_cmd.load && (i_command != msl_pkg::CMD_TICK) && in_range;

    assign o_status.is_tick = (i_command == msl_pkg::CMD_TICK);
    assign o_status.empty   = (live_n == '0);
    assign o_status.last    = ((32'(r_idx) + 1) == 32'(live_n));

    // Init value of the current angle: one degree above, saturating.
    logic [CW-1:0] init_cur;
    always_comb begin
        if (i_angle == '1) begin
            init_cur = CUR_MAX;
        end else begin
            init_cur = CW'(i_angle + ANG_W'(1)) << FRACTION_BITS;
        end
    end

    logic signed [ANG_W+1:0] set_x;
    logic signed [ANG_W+1:0] chg_x;
    assign set_x = $signed({2'b00, i_angle});
    assign chg_x = $signed({2'b00, r_tgt[wr_idx]}) + (ANG_W+2)'(i_bias);

    // Step computation for the channel in flight.
    logic [CW-1:0] cur;
    logic [CW-1:0] tgt_fx;
    logic [CW-1:0] gap;
    logic          up;
    logic          do_step;
    logic [CW-1:0] new_cur;
    always_comb begin
        cur     = r_cur[r_idx];
        tgt_fx  = CW'(r_tgt[r_idx]) << FRACTION_BITS;
        up      = tgt_fx > cur;
        gap     = up ? (tgt_fx - cur) : (cur - tgt_fx);
        do_step = gap >= CW'(i_cfg.step);
        new_cur = up ? (cur + CW'(i_cfg.step)) : (cur - CW'(i_cfg.step));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_lim_lo[k] <= '0;
                r_lim_hi[k] <= msl_pkg::LIM_HI_RST;
                r_tgt[k]    <= '0;
                r_cur[k]    <= '0;
            end
        end else if (edit) begin
            unique case (msl_pkg::t_cmd'(i_command))
                msl_pkg::CMD_INIT: begin
                    r_lim_lo[wr_idx] <= i_min_angle;
                    r_lim_hi[wr_idx] <= i_max_angle;
                    r_tgt[wr_idx]    <= i_angle;
                    r_cur[wr_idx]    <= init_cur;
                end
                msl_pkg::CMD_SET: begin
                    r_tgt[wr_idx] <= clamp_lim(set_x, r_lim_lo[wr_idx], r_lim_hi[wr_idx]);
                end
                msl_pkg::CMD_CHANGE: begin
                    r_tgt[wr_idx] <= clamp_lim(chg_x, r_lim_lo[wr_idx], r_lim_hi[wr_idx]);
                end
                default: begin
                end
            endcase
        end else if (i_cmd.step && do_step) begin
            r_cur[r_idx] <= new_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.next) begin
            r_idx <= r_idx + CH_W'(1);
        end
    end

    // Arithmetic stages, one per controller state.
    logic [FULL_W-1:0]  q_full;
    logic [PROD_W-1:0]  rem;
    logic [QUO_W-1:0]   quo;
    logic signed [PSUM_W-1:0] psum;
    logic [PULSE_W-1:0] psat;
    always_comb begin
        q_full = FULL_W'(r_prod) * FULL_W'(msl_pkg::DIV_RECIP);
        rem    = r_prod - PROD_W'(r_quo0) * PROD_W'(msl_pkg::FULL_SCALE_DEG);
        quo    = (rem >= PROD_W'(msl_pkg::FULL_SCALE_DEG)) ? (r_quo0 + QUO_W'(1)) : r_quo0;
        psum   = $signed({3'b000, i_cfg.pmin}) + PSUM_W'(r_qs);
        if (psum < 0) begin
            psat = '0;
        end else if (psum > PSUM_W'(msl_pkg::PULSE_CAP)) begin
            psat = PULSE_W'(msl_pkg::PULSE_CAP);
        end else begin
            psat = psum[PULSE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_moved <= do_step;
            r_last  <= o_status.last;
            r_ch    <= r_idx;
            r_deg   <= do_step ? new_cur[CW-1 -: ANG_W] : cur[CW-1 -: ANG_W];
            r_neg   <= i_cfg.pmax < i_cfg.pmin;
            r_mag   <= (i_cfg.pmax < i_cfg.pmin) ? (i_cfg.pmin - i_cfg.pmax)
                                                 : (i_cfg.pmax - i_cfg.pmin);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_deg) * PROD_W'(r_mag);
        end
        if (i_cmd.div) begin
            r_quo0 <= q_full[msl_pkg::DIV_SHIFT +: QUO_W];
        end
        if (i_cmd.fix) begin
            r_qs <= r_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
        if (i_cmd.emit) begin
            o_out_channel <= msl_pkg::CHPORT_W'(r_ch);
            o_pulse_us    <= r_moved ? psat : '0;
            o_moved       <= r_moved;
            o_last        <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

endmodule

// ===== design/multi_servo_slew_limiter_core.sv =====
// Top level of the multi-servo slew limiter: configuration registers and core wiring.
//
//  Channel   Signals                                   Transfer
//  --------  ----------------------------------------  --------------------------------
//  command   start, busy, i_command .. i_max_angle     word taken when start & !busy
//  result    o_valid, o_out_channel, o_pulse_us,       one cycle per word, no stall
//            o_moved, o_last
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    written when valid & ready
//            i_cfg_data
//
// Init, set and change words for an active channel are applied at the edge that
// accepts them; busy never rises for them. A tick visits the active channels one
// after another, and each channel passes through five controller states (step,
// multiply, reciprocal multiply, correction, output), so a tick holds busy until
// the last active channel leaves its output state; a tick with no active channels
// leaves busy low. Each result word appears in the cycle after its output state.
// Reset is synchronous and active low; it loads the register defaults and the
// per-channel limits, targets and angles. The receiver cannot stall results.
module multi_servo_slew_limiter_core #(
    parameter int CHANNELS      = msl_pkg::CHANNELS_DEF,
    parameter int FRACTION_BITS = msl_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel.
    input  logic                                start,
    output logic                                busy,
    input  logic [msl_pkg::CMD_W-1:0]           i_command,
    input  logic [msl_pkg::CHPORT_W-1:0]        i_channel,
    input  logic [msl_pkg::ANG_W-1:0]           i_angle,
    input  logic signed [msl_pkg::ANG_W-1:0]    i_bias,
    input  logic [msl_pkg::ANG_W-1:0]           i_min_angle,
    input  logic [msl_pkg::ANG_W-1:0]           i_max_angle,
    // Result channel.
    output logic                                o_valid,
    output logic [msl_pkg::CHPORT_W-1:0]        o_out_channel,
    output logic [msl_pkg::PULSE_W-1:0]         o_pulse_us,
    output logic                                o_moved,
    output logic                                o_last,
    // Configuration channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msl_pkg::CFGIDX_W-1:0]        i_cfg_index,
    input  logic [msl_pkg::PULSE_W-1:0]         i_cfg_data
);

    msl_pkg::t_cfg       r_cfg;
    msl_pkg::t_dp_cmd    dp_cmd;
    msl_pkg::t_dp_status dp_status;

    // The register file is always ready; each write is registered when accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active <= msl_pkg::ACTIVE_RST;
            r_cfg.step   <= msl_pkg::STEP_RST;
            r_cfg.pmin   <= msl_pkg::PMIN_RST;
            r_cfg.pmax   <= msl_pkg::PMAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (msl_pkg::t_reg'(i_cfg_index))
                msl_pkg::REG_ACTIVE: r_cfg.active <= i_cfg_data[msl_pkg::ACT_W-1:0];
                msl_pkg::REG_STEP:   r_cfg.step   <= i_cfg_data[msl_pkg::STEP_W-1:0];
                msl_pkg::REG_PMIN:   r_cfg.pmin   <= i_cfg_data;
                msl_pkg::REG_PMAX:   r_cfg.pmax   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The controller sequences; the datapath holds all channel state and math.
    msl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    msl_datapath #(
        .CHANNELS      (CHANNELS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_angle       (i_angle),
        .i_bias        (i_bias),
        .i_min_angle   (i_min_angle),
        .i_max_angle   (i_max_angle),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_pulse_us    (o_pulse_us),
        .o_moved       (o_moved),
        .o_last        (o_last)
    );

    // A result word only follows an output state of the controller.
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(dp_cmd.emit))
        else $error("result strobe without a preceding output state");

    // Output states never follow each other, so strobes never come back to back.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes on consecutive cycles");

    // A channel that did not move reports a zero pulse width.
    a_unmoved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_moved) |-> (o_pulse_us == '0))
        else $error("unmoved channel reports a pulse width");

    // A tick with active channels keeps the block busy afterward.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load && dp_status.is_tick && !dp_status.empty) |=> busy)
        else $error("accepted tick did not start a sweep");

    // Non-tick commands never occupy the block.
    a_edit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load && !dp_status.is_tick) |=> !busy)
        else $error("edit command left the block busy");

endmodule
